### rtl/assert_macros.svh
// Assertion macros shared by the downsampler RTL.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: the consequent holds in the same cycle.
`define IBAD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ibad assertion failed");

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define IBAD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ibad assertion failed");

`endif

### rtl/ibad_pkg.sv
// Shared constants, codes and control/status types of the downsampler.
// Used by every module of the block but ibad_ram; depends on nothing.
package ibad_pkg;

  localparam int MAX_COLS       = 2048;
  localparam int MAX_ROWS       = 2048;
  localparam int STEP_FRAC_BITS = 8;

  localparam int PIX_W      = 8;
  localparam int STEP_W     = 13;
  localparam int SIZE_W     = 12;
  localparam int POS_W      = 11;
  localparam int IDX_W      = 12;
  localparam int EDGE_W     = IDX_W + STEP_FRAC_BITS;
  localparam int SUM_W      = 16;
  localparam int BIN_W      = 5;
  localparam int CNT_W      = 2 * BIN_W;
  localparam int ADDR_W     = $clog2(MAX_COLS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = STEP_W;
  localparam int DIVN_W     = SIZE_W + STEP_FRAC_BITS;
  localparam int DIVD_W     = STEP_W;
  localparam int DIVC_W     = $clog2(DIVN_W + 1);

  localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(1 << STEP_FRAC_BITS);
  localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(16 << STEP_FRAC_BITS);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(640);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1200);
  localparam logic [PIX_W-1:0]  PIX_FULL   = PIX_W'(255);

  localparam logic [CFG_IDX_W-1:0] CFG_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    DIV_NCOL,
    DIV_NROW,
    DIV_MEAN
  } div_sel_e;

  typedef struct packed {
    logic     clear;
    logic     accept;
    logic     update;
    logic     div_start;
    div_sel_e div_sel;
    logic     take_ncol;
    logic     take_nrow;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic restart;
    logic emit;
    logic div_busy;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/ibad_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module ibad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ibad_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on ibad_pkg for operand widths.
module ibad_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ibad_pkg::DIVN_W-1:0]  dividend_i,
  input  logic [ibad_pkg::DIVD_W-1:0]  divisor_i,
  output logic                         busy_o,
  output logic [ibad_pkg::DIVN_W-1:0]  quotient_o
);

  logic                          busy_q;
  logic [ibad_pkg::DIVC_W-1:0]   cnt_q;
  logic [ibad_pkg::DIVD_W:0]     rem_q;
  logic [ibad_pkg::DIVD_W:0]     rem_d;
  logic [ibad_pkg::DIVD_W:0]     rem_sh;
  logic [ibad_pkg::DIVN_W-1:0]   quo_q;
  logic [ibad_pkg::DIVD_W-1:0]   div_q;
  logic                          ge;

  always_comb begin
    rem_sh = {rem_q[ibad_pkg::DIVD_W-1:0], quo_q[ibad_pkg::DIVN_W-1]};
    ge     = rem_sh >= {1'b0, div_q};
    rem_d  = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= ibad_pkg::DIVC_W'(ibad_pkg::DIVN_W);
    end else if (busy_q) begin
      busy_q <= (cnt_q != ibad_pkg::DIVC_W'(1));
      cnt_q  <= cnt_q - ibad_pkg::DIVC_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[ibad_pkg::DIVN_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

### rtl/ibad_ctrl.sv
// Controller state machine: setup divisions, pixel sequencing and result hand-off.
// Depends on ibad_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ibad_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  ibad_pkg::dp_sts_t   sts_i,
  output ibad_pkg::ctrl_cmd_t cmd_o,
  output logic                in_stall_o
);

  localparam logic [2:0] S_SETUP  = 3'd0;
  localparam logic [2:0] S_NCOL   = 3'd1;
  localparam logic [2:0] S_NROW   = 3'd2;
  localparam logic [2:0] S_IDLE   = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_MEAN   = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  assign in_stall_o = (state_q != S_IDLE) || sts_i.restart;

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = ibad_pkg::DIV_NCOL;
    state_d       = state_q;
    unique case (state_q)
      S_SETUP: begin
        cmd_o.clear     = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = ibad_pkg::DIV_NCOL;
        state_d         = S_NCOL;
      end
      S_NCOL: begin
        if (!sts_i.div_busy) begin
          cmd_o.take_ncol = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = ibad_pkg::DIV_NROW;
          state_d         = S_NROW;
        end
      end
      S_NROW: begin
        if (!sts_i.div_busy) begin
          cmd_o.take_nrow = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i && !sts_i.restart) begin
          cmd_o.accept = 1'b1;
          state_d      = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        if (sts_i.emit) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = ibad_pkg::DIV_MEAN;
          state_d         = S_MEAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MEAN: begin
        if (!sts_i.div_busy && sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_SETUP;
      end
    endcase
    if (sts_i.restart) begin
      state_d = S_SETUP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SETUP;
    end else begin
      state_q <= state_d;
    end
  end

  `IBAD_ASSERT_NEXT(a_plain_pixel_returns,
                    state_q == S_UPDATE && !sts_i.emit && !sts_i.restart,
                    state_q == S_IDLE)
  `IBAD_ASSERT_IMPL(a_start_on_idle_divider,
                    cmd_o.div_start && state_q != S_SETUP,
                    !sts_i.div_busy)
  `IBAD_ASSERT_IMPL(a_accept_when_ready,
                    cmd_o.accept,
                    state_q == S_IDLE && !sts_i.div_busy && !sts_i.restart)

endmodule

### rtl/ibad_dp.sv
// Datapath: configuration registers, bin position state, column sum RAM,
// shared divider and output register. Depends on ibad_pkg, ibad_ram, ibad_div.
`include "assert_macros.svh"

module ibad_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ibad_pkg::ctrl_cmd_t               cmd_i,
  output ibad_pkg::dp_sts_t                 sts_o,
  input  logic                              cfg_we_i,
  input  logic [ibad_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ibad_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [ibad_pkg::PIX_W-1:0]        pixel_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [ibad_pkg::PIX_W-1:0]        mean_value_o,
  output logic [ibad_pkg::POS_W-1:0]        bin_col_o,
  output logic [ibad_pkg::POS_W-1:0]        bin_row_o,
  output logic                              frame_done_o
);

  // Configuration and derived sizes.
  logic [ibad_pkg::STEP_W-1:0] step_q;
  logic [ibad_pkg::SIZE_W-1:0] rows_q;
  logic [ibad_pkg::SIZE_W-1:0] cols_q;
  logic [ibad_pkg::STEP_W-1:0] s_eff;
  logic [ibad_pkg::SIZE_W-1:0] rows_eff;
  logic [ibad_pkg::SIZE_W-1:0] cols_eff;
  logic [ibad_pkg::EDGE_W-1:0] s_ext;
  logic [ibad_pkg::IDX_W-1:0]  ncol_q;
  logic [ibad_pkg::IDX_W-1:0]  nrow_q;
  logic                        restart;

  // Position state.
  logic [ibad_pkg::POS_W-1:0]  in_col_q, in_col_d;
  logic [ibad_pkg::POS_W-1:0]  in_row_q, in_row_d;
  logic [ibad_pkg::IDX_W-1:0]  out_col_q, out_col_d;
  logic [ibad_pkg::IDX_W-1:0]  out_row_q, out_row_d;
  logic [ibad_pkg::EDGE_W-1:0] col_edge_q, col_edge_d;
  logic [ibad_pkg::EDGE_W-1:0] row_edge_q, row_edge_d;
  logic [ibad_pkg::IDX_W-1:0]  band_first_q, band_first_d;

  // Per-pixel work.
  logic [ibad_pkg::PIX_W-1:0]  inv_q;
  logic [ibad_pkg::SUM_W-1:0]  ram_rdata;
  logic [ibad_pkg::SUM_W-1:0]  acc_new;
  logic [ibad_pkg::EDGE_W-1:0] start_edge;
  logic [ibad_pkg::IDX_W-1:0]  start_x;
  logic [ibad_pkg::IDX_W-1:0]  end_x;
  logic [ibad_pkg::IDX_W-1:0]  end_y;
  logic [ibad_pkg::IDX_W-1:0]  x_inc;
  logic [ibad_pkg::IDX_W-1:0]  y_inc;
  logic [ibad_pkg::IDX_W-1:0]  wx;
  logic [ibad_pkg::IDX_W-1:0]  wy;
  logic [ibad_pkg::CNT_W-1:0]  count;
  logic                        in_bin;
  logic                        init;
  logic                        col_last;
  logic                        row_last;
  logic                        line_end;
  logic                        frame_end;
  logic                        emit;
  logic                        ram_we;

  // Divider and result.
  logic [ibad_pkg::DIVN_W-1:0] div_dividend;
  logic [ibad_pkg::DIVD_W-1:0] div_divisor;
  logic [ibad_pkg::DIVN_W-1:0] div_quo;
  logic                        div_busy;
  logic [ibad_pkg::POS_W-1:0]  em_col_q;
  logic [ibad_pkg::POS_W-1:0]  em_row_q;
  logic                        em_done_q;
  logic                        em_zero_q;
  logic                        out_valid_q;
  logic [ibad_pkg::PIX_W-1:0]  mean_q;
  logic [ibad_pkg::POS_W-1:0]  col_q;
  logic [ibad_pkg::POS_W-1:0]  row_q;
  logic                        done_q;
  logic                        out_free;

  assign restart = cfg_we_i && (cfg_index_i == ibad_pkg::CFG_STEP ||
                                cfg_index_i == ibad_pkg::CFG_ROWS ||
                                cfg_index_i == ibad_pkg::CFG_COLS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ibad_pkg::STEP_RESET;
      rows_q <= ibad_pkg::SIZE_RESET;
      cols_q <= ibad_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ibad_pkg::CFG_STEP: step_q <= cfg_data_i;
        ibad_pkg::CFG_ROWS: rows_q <= cfg_data_i[ibad_pkg::SIZE_W-1:0];
        ibad_pkg::CFG_COLS: cols_q <= cfg_data_i[ibad_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (step_q < ibad_pkg::STEP_MIN) begin
      s_eff = ibad_pkg::STEP_MIN;
    end else if (step_q > ibad_pkg::STEP_MAX) begin
      s_eff = ibad_pkg::STEP_MAX;
    end else begin
      s_eff = step_q;
    end
    if (rows_q == '0) begin
      rows_eff = ibad_pkg::SIZE_W'(1);
    end else if (rows_q > ibad_pkg::SIZE_W'(ibad_pkg::MAX_ROWS)) begin
      rows_eff = ibad_pkg::SIZE_W'(ibad_pkg::MAX_ROWS);
    end else begin
      rows_eff = rows_q;
    end
    if (cols_q == '0) begin
      cols_eff = ibad_pkg::SIZE_W'(1);
    end else if (cols_q > ibad_pkg::SIZE_W'(ibad_pkg::MAX_COLS)) begin
      cols_eff = ibad_pkg::SIZE_W'(ibad_pkg::MAX_COLS);
    end else begin
      cols_eff = cols_q;
    end
  end

  assign s_ext = ibad_pkg::EDGE_W'(s_eff);

  // Bin geometry of the current pixel.
  always_comb begin
    start_edge = col_edge_q - s_ext;
    start_x    = start_edge[ibad_pkg::EDGE_W-1:ibad_pkg::STEP_FRAC_BITS];
    end_x      = col_edge_q[ibad_pkg::EDGE_W-1:ibad_pkg::STEP_FRAC_BITS];
    end_y      = row_edge_q[ibad_pkg::EDGE_W-1:ibad_pkg::STEP_FRAC_BITS];
    x_inc      = ibad_pkg::IDX_W'(in_col_q) + ibad_pkg::IDX_W'(1);
    y_inc      = ibad_pkg::IDX_W'(in_row_q) + ibad_pkg::IDX_W'(1);
    wx         = end_x - start_x;
    wy         = end_y - band_first_q;
    count      = wx[ibad_pkg::BIN_W-1:0] * wy[ibad_pkg::BIN_W-1:0];
    in_bin     = (out_col_q < ncol_q) && (out_row_q < nrow_q);
    init       = (ibad_pkg::IDX_W'(in_row_q) == band_first_q) &&
                 (ibad_pkg::IDX_W'(in_col_q) == start_x);
    acc_new    = init ? ibad_pkg::SUM_W'(inv_q)
                      : ram_rdata + ibad_pkg::SUM_W'(inv_q);
    col_last   = x_inc == end_x;
    row_last   = y_inc == end_y;
    line_end   = x_inc >= cols_eff;
    frame_end  = y_inc >= rows_eff;
    emit       = in_bin && col_last && row_last;
    ram_we     = cmd_i.update && in_bin;
  end

  // Next position state.
  always_comb begin
    in_col_d     = in_col_q;
    in_row_d     = in_row_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    col_edge_d   = col_edge_q;
    row_edge_d   = row_edge_q;
    band_first_d = band_first_q;
    if (cmd_i.clear) begin
      in_col_d     = '0;
      in_row_d     = '0;
      out_col_d    = '0;
      out_row_d    = '0;
      band_first_d = '0;
      col_edge_d   = s_ext;
      row_edge_d   = s_ext;
    end else if (cmd_i.update) begin
      if (in_bin && col_last) begin
        out_col_d  = out_col_q + ibad_pkg::IDX_W'(1);
        col_edge_d = col_edge_q + s_ext;
      end
      if (line_end) begin
        in_col_d   = '0;
        out_col_d  = '0;
        col_edge_d = s_ext;
        if (row_last && out_row_q < nrow_q) begin
          out_row_d    = out_row_q + ibad_pkg::IDX_W'(1);
          band_first_d = y_inc;
          row_edge_d   = row_edge_q + s_ext;
        end
        if (frame_end) begin
          in_row_d     = '0;
          out_row_d    = '0;
          band_first_d = '0;
          row_edge_d   = s_ext;
        end else begin
          in_row_d = y_inc[ibad_pkg::POS_W-1:0];
        end
      end else begin
        in_col_d = x_inc[ibad_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q     <= '0;
      in_row_q     <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      band_first_q <= '0;
      col_edge_q   <= ibad_pkg::EDGE_W'(ibad_pkg::STEP_RESET);
      row_edge_q   <= ibad_pkg::EDGE_W'(ibad_pkg::STEP_RESET);
      ncol_q       <= '0;
      nrow_q       <= '0;
    end else begin
      in_col_q     <= in_col_d;
      in_row_q     <= in_row_d;
      out_col_q    <= out_col_d;
      out_row_q    <= out_row_d;
      band_first_q <= band_first_d;
      col_edge_q   <= col_edge_d;
      row_edge_q   <= row_edge_d;
      if (cmd_i.take_ncol) begin
        ncol_q <= div_quo[ibad_pkg::IDX_W-1:0];
      end
      if (cmd_i.take_nrow) begin
        nrow_q <= div_quo[ibad_pkg::IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      inv_q <= ibad_pkg::PIX_FULL - pixel_i;
    end
    if (cmd_i.update && emit) begin
      em_col_q  <= out_col_q[ibad_pkg::POS_W-1:0];
      em_row_q  <= out_row_q[ibad_pkg::POS_W-1:0];
      em_done_q <= (out_col_q + ibad_pkg::IDX_W'(1) == ncol_q) &&
                   (out_row_q + ibad_pkg::IDX_W'(1) == nrow_q);
      em_zero_q <= count == '0;
    end
  end

  ibad_ram #(
    .WIDTH(ibad_pkg::SUM_W),
    .DEPTH(ibad_pkg::MAX_COLS)
  ) u_sums (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(out_col_q[ibad_pkg::ADDR_W-1:0]),
    .wdata_i(acc_new),
    .re_i   (cmd_i.accept),
    .raddr_i(out_col_q[ibad_pkg::ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    unique case (cmd_i.div_sel)
      ibad_pkg::DIV_NCOL: begin
        div_dividend = {cols_eff, {ibad_pkg::STEP_FRAC_BITS{1'b0}}};
        div_divisor  = s_eff;
      end
      ibad_pkg::DIV_NROW: begin
        div_dividend = {rows_eff, {ibad_pkg::STEP_FRAC_BITS{1'b0}}};
        div_divisor  = s_eff;
      end
      ibad_pkg::DIV_MEAN: begin
        div_dividend = ibad_pkg::DIVN_W'(acc_new);
        div_divisor  = ibad_pkg::DIVD_W'(count);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = s_eff;
      end
    endcase
  end

  ibad_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .quotient_o(div_quo)
  );

  // Output register.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mean_q <= em_zero_q ? '0 : div_quo[ibad_pkg::PIX_W-1:0];
      col_q  <= em_col_q;
      row_q  <= em_row_q;
      done_q <= em_done_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mean_value_o = mean_q;
  assign bin_col_o    = col_q;
  assign bin_row_o    = row_q;
  assign frame_done_o = done_q;

  always_comb begin
    sts_o          = '0;
    sts_o.restart  = restart;
    sts_o.emit     = emit;
    sts_o.div_busy = div_busy;
    sts_o.out_free = out_free;
  end

  `IBAD_ASSERT_IMPL(a_load_never_overwrites, cmd_i.out_load, out_free)
  `IBAD_ASSERT_IMPL(a_bin_within_grid, 1'b1,
                    out_col_q <= ncol_q && out_row_q <= nrow_q)

endmodule

### rtl/inverted_box_average_downsampler.sv
// Top level of the inverted box-average downsampler.
// Depends on ibad_pkg, ibad_ctrl and ibad_dp.
//
//   Channel   Signals                                      Beat taken when
//   pixel in  in_valid_i, in_stall_o, pixel_i              in_valid_i && !in_stall_o
//   result    out_valid_o, out_stall_i, mean_value_o,      out_valid_o && !out_stall_i
//             bin_col_o, bin_row_o, frame_done_o
//   config    cfg_we_i, cfg_index_i, cfg_data_i            cfg_we_i
//
// A pixel that closes no bin is accepted with the column sum RAM read, then updated.
// A pixel that closes a bin also waits for the 20-step shared divider to compute the mean.
// After reset and after each write to the step, rows or cols register the block stalls input
// while the same divider computes the output columns and rows.
// A stalled result sits in the output register; the next pixel is still accepted unless
// another result must be loaded.
module inverted_box_average_downsampler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ibad_pkg::PIX_W-1:0]        pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ibad_pkg::PIX_W-1:0]        mean_value_o,
  output logic [ibad_pkg::POS_W-1:0]        bin_col_o,
  output logic [ibad_pkg::POS_W-1:0]        bin_row_o,
  output logic                              frame_done_o,
  input  logic                              cfg_we_i,
  input  logic [ibad_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ibad_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  ibad_pkg::ctrl_cmd_t cmd;
  ibad_pkg::dp_sts_t   sts;

  ibad_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .in_stall_o(in_stall_o)
  );

  ibad_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (pixel_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .mean_value_o(mean_value_o),
    .bin_col_o   (bin_col_o),
    .bin_row_o   (bin_row_o),
    .frame_done_o(frame_done_o)
  );

endmodule
